// ----- rtl/core/bjsl_pkg.sv -----
// Package for the slope limiter: shared widths and parameter defaults.
// No dependencies; used by every module of the block.
package bjsl_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int AVG_W         = 32;
    localparam int DIFF_W        = AVG_W + 1;

endpackage

// ----- rtl/core/bjsl_lane.sv -----
// One vertex lane: difference, bound selection, scaled numerator and a
// bit-per-stage restoring divider. Depends on bjsl_pkg.
module bjsl_lane
    import bjsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NS = FRAC_BITS + 5
) (
    input  logic                    i_clk,
    input  logic [NS-1:0]           i_en,
    input  logic [FRAC_BITS:0]      i_scale,
    input  logic signed [AVG_W-1:0] i_vert,
    input  logic signed [AVG_W-1:0] i_avg_t,
    input  logic signed [AVG_W-1:0] i_avg_n,
    output logic [FRAC_BITS:0]      o_quot,
    output logic                    o_force_one
);

    localparam int CW = DIFF_W + FRAC_BITS + 1;
    localparam int NB = FRAC_BITS + 1;

    logic signed [AVG_W-1:0]  r_vert, r_avg_t, r_avg_n;
    logic [DIFF_W-1:0]        r_num, r_den1, r_den2;
    logic                     r_zero1, r_zero2;
    logic [CW-1:0]            r_prod;

    logic signed [DIFF_W-1:0] n_diff;
    logic [DIFF_W-1:0]        n_num, n_den;

    logic [CW-1:0]            r_rem  [NB+1];
    logic [DIFF_W-1:0]        r_dq   [NB+1];
    logic [FRAC_BITS:0]       r_quot [NB+1];
    logic                     r_flag [NB+1];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_vert  <= i_vert;
            r_avg_t <= i_avg_t;
            r_avg_n <= i_avg_n;
        end
    end

    always_comb begin
        n_diff = DIFF_W'(r_vert) - DIFF_W'(r_avg_t);
        n_num  = '0;
        n_den  = '0;
        if (!n_diff[DIFF_W-1]) begin
            n_den = n_diff;
            if (r_avg_n > r_avg_t) begin
                n_num = DIFF_W'(r_avg_n) - DIFF_W'(r_avg_t);
            end
        end else begin
            n_den = -n_diff;
            if (r_avg_n < r_avg_t) begin
                n_num = DIFF_W'(r_avg_t) - DIFF_W'(r_avg_n);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num   <= n_num;
            r_den1  <= n_den;
            r_zero1 <= (n_diff == '0);
        end
        if (i_en[2]) begin
            r_prod  <= CW'(i_scale) * CW'(r_num);
            r_den2  <= r_den1;
            r_zero2 <= r_zero1;
        end
        // A quotient of two or more is caught here; below it the divider
        // only needs FRAC_BITS+1 quotient bits.
        if (i_en[3]) begin
            r_rem[0]  <= r_prod;
            r_dq[0]   <= r_den2;
            r_quot[0] <= '0;
            r_flag[0] <= r_zero2 || (r_prod >= (CW'(r_den2) << NB));
        end
    end

    for (genvar j = 0; j < NB; j++) begin : g_div
        logic [CW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = CW'(r_dq[j]) << (FRAC_BITS - j);
        assign w_ge = (r_rem[j] >= w_sh);
        always_ff @(posedge i_clk) begin
            if (i_en[4+j]) begin
                r_rem[j+1]  <= w_ge ? r_rem[j] - w_sh : r_rem[j];
                r_dq[j+1]   <= r_dq[j];
                r_quot[j+1] <= {r_quot[j][FRAC_BITS-1:0], w_ge};
                r_flag[j+1] <= r_flag[j];
            end
        end
    end

    assign o_quot      = r_quot[NB];
    assign o_force_one = r_flag[NB];

endmodule

// ----- rtl/core/bjsl_merge.sv -----
// Merge stage: clamps each lane's quotient at one and keeps the smaller.
// Depends on bjsl_pkg.
module bjsl_merge
    import bjsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [FRAC_BITS:0]  i_quot_l,
    input  logic                i_one_l,
    input  logic [FRAC_BITS:0]  i_quot_r,
    input  logic                i_one_r,
    output logic [FRAC_BITS:0]  o_phi
);

    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] w_pl, w_pr;
    logic [FRAC_BITS:0] r_phi;

    assign w_pl = (i_one_l || i_quot_l > ONE) ? ONE : i_quot_l;
    assign w_pr = (i_one_r || i_quot_r > ONE) ? ONE : i_quot_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phi <= (w_pl < w_pr) ? w_pl : w_pr;
        end
    end

    assign o_phi = r_phi;

endmodule

// ----- rtl/core/barth_jespersen_slope_limiter_top.sv -----
// Throughput: one cell per cycle while the output is accepted; the two
// vertex lanes and the divider are fully pipelined, one quotient bit per
// stage, and each stage stalls only when the stage after it is full.
// Reset (synchronous, active low) empties the pipeline and sets the limiter
// scale to 1.0. Depends on bjsl_pkg, bjsl_lane, bjsl_merge.
module barth_jespersen_slope_limiter_top
    import bjsl_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [FRAC_BITS:0]      i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [AVG_W-1:0] i_vertex_left,
    input  logic signed [AVG_W-1:0] i_vertex_right,
    input  logic signed [AVG_W-1:0] i_avg_left,
    input  logic signed [AVG_W-1:0] i_avg_target,
    input  logic signed [AVG_W-1:0] i_avg_right,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [FRAC_BITS:0]      o_limiter_factor
);

    localparam int NS = FRAC_BITS + 5;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic [FRAC_BITS:0] r_scale;
    logic [NS:0]        r_vld;
    logic [NS:0]        w_en;
    logic [FRAC_BITS:0] w_ql, w_qr;
    logic               w_ol, w_or;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ONE;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_data;
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        w_en[NS] = !r_vld[NS] || i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s <= NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    bjsl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_l (
        .i_clk       (i_clk),
        .i_en        (w_en[NS-1:0]),
        .i_scale     (r_scale),
        .i_vert      (i_vertex_left),
        .i_avg_t     (i_avg_target),
        .i_avg_n     (i_avg_left),
        .o_quot      (w_ql),
        .o_force_one (w_ol)
    );

    bjsl_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
        .i_clk       (i_clk),
        .i_en        (w_en[NS-1:0]),
        .i_scale     (r_scale),
        .i_vert      (i_vertex_right),
        .i_avg_t     (i_avg_target),
        .i_avg_n     (i_avg_right),
        .o_quot      (w_qr),
        .o_force_one (w_or)
    );

    bjsl_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en[NS]),
        .i_quot_l (w_ql),
        .i_one_l  (w_ol),
        .i_quot_r (w_qr),
        .i_one_r  (w_or),
        .o_phi    (o_limiter_factor)
    );

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS];

`ifndef SYNTHESIS
    // The input side only stalls when the result register is full and held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while result register free");

    a_phi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_limiter_factor <= ONE))
        else $error("limiter factor above one");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule
